FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with active-low reset disable.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Assertion on the block clock and reset.
`define ASSERT_ACLK(label, prop, msg) \
    `ASSERT_CLK_RST(label, aclk, aresetn, prop, msg)

`endif

FILE: sv/lmps_pkg.sv
// ----------------------------------------------------------------------------
// lmps_pkg
// Mode codes, register indexes and reset values of the LED PWM sequencer.
// ----------------------------------------------------------------------------
package lmps_pkg;

    localparam int MODE_W     = 3;
    localparam int PERIOD_W   = 16;
    localparam int STEP_W     = 8;
    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 10;
    localparam int DUTY_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [PERIOD_W-1:0]  period_t;
    typedef logic [STEP_W-1:0]    step_t;
    typedef logic [TIME_W-1:0]    time_ms_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam mode_t MODE_DARK   = 3'd0;
    localparam mode_t MODE_ON     = 3'd1;
    localparam mode_t MODE_BLINK  = 3'd2;
    localparam mode_t MODE_FLASH  = 3'd3;
    localparam mode_t MODE_BREATH = 3'd4;

    localparam cfg_idx_t REG_LED_MODE      = 3'd0;
    localparam cfg_idx_t REG_SLOW_HALF     = 3'd1;
    localparam cfg_idx_t REG_STROBE_HALF   = 3'd2;
    localparam cfg_idx_t REG_BREATH_INTVL  = 3'd3;
    localparam cfg_idx_t REG_BREATH_STEP   = 3'd4;

    localparam mode_t   RST_LED_MODE     = MODE_DARK;
    localparam period_t RST_SLOW_HALF    = 16'd500;
    localparam period_t RST_STROBE_HALF  = 16'd50;
    localparam period_t RST_BREATH_INTVL = 16'd10;
    localparam step_t   RST_BREATH_STEP  = 8'd5;

endpackage

FILE: sv/lmps_breath.sv
// ----------------------------------------------------------------------------
// lmps_breath
// One breathing step: ramp the level, clamp at the ends and turn around.
// ----------------------------------------------------------------------------
module lmps_breath
    import lmps_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  logic [DUTY_BITS-1:0] level,
    input  logic                 falling,
    input  step_t                step,
    output logic [DUTY_BITS-1:0] level_next,
    output logic                 falling_next
);

    localparam logic [DUTY_BITS-1:0] FULL = {DUTY_BITS{1'b1}};

    logic [DUTY_BITS-1:0] step_d;
    logic [DUTY_BITS-1:0] top;

    assign step_d = {{(DUTY_BITS-STEP_W){1'b0}}, step};
    // top threshold saturates at zero for a step at or above full scale
    assign top    = (step_d >= FULL) ? '0 : (FULL - step_d);

    always_comb begin
        level_next   = level;
        falling_next = falling;
        if (!falling) begin
            if (level >= top) begin
                level_next   = FULL;
                falling_next = 1'b1;
            end else begin
                level_next = level + step_d;
            end
        end else begin
            if (level <= step_d) begin
                level_next   = '0;
                falling_next = 1'b0;
            end else begin
                level_next = level - step_d;
            end
        end
    end

endmodule

FILE: sv/led_mode_pwm_sequencer_unit.sv
// ----------------------------------------------------------------------------
// led_mode_pwm_sequencer_unit
// LED PWM duty sequencer: off, on, slow blink, strobe and breathing modes.
// ----------------------------------------------------------------------------
// Output: m_valid rises in the cycle after an item is accepted (output register).
// Throughput: one item per cycle; s_ready drops only while a result is held
//   by m_ready low, set by the single output register.
// Reset: synchronous active-low aresetn clears all mode state and m_valid
//   (not m_duty) and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_mode_pwm_sequencer_unit
    import lmps_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // item input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  time_ms_t              s_now_ms,
    input  logic [SAMPLE_W-1:0]   s_brightness_sample,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DUTY_W-1:0]     m_duty,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [DUTY_BITS-1:0] FULL = {DUTY_BITS{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    mode_t   mode_reg;
    period_t slow_half_reg;
    period_t strobe_half_reg;
    period_t breath_intvl_reg;
    step_t   breath_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= RST_LED_MODE;
            slow_half_reg    <= RST_SLOW_HALF;
            strobe_half_reg  <= RST_STROBE_HALF;
            breath_intvl_reg <= RST_BREATH_INTVL;
            breath_step_reg  <= RST_BREATH_STEP;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LED_MODE:     mode_reg         <= cfg_wdata[MODE_W-1:0];
                REG_SLOW_HALF:    slow_half_reg    <= cfg_wdata[PERIOD_W-1:0];
                REG_STROBE_HALF:  strobe_half_reg  <= cfg_wdata[PERIOD_W-1:0];
                REG_BREATH_INTVL: breath_intvl_reg <= cfg_wdata[PERIOD_W-1:0];
                REG_BREATH_STEP:  breath_step_reg  <= cfg_wdata[STEP_W-1:0];
                default: ;  // indexes beyond the register list are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Mode state
    // ------------------------------------------------------------------
    logic [DUTY_BITS-1:0] duty_reg,        duty_next;
    time_ms_t             slow_last_reg,   slow_last_next;
    logic                 slow_on_reg,     slow_on_next;
    time_ms_t             strobe_last_reg, strobe_last_next;
    logic                 strobe_on_reg,   strobe_on_next;
    logic [DUTY_BITS-1:0] breath_level_reg, breath_level_next;
    time_ms_t             breath_last_reg, breath_last_next;
    logic                 breath_falling_reg, breath_falling_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [DUTY_W-1:0]    m_duty_reg;

    logic accept;

    // the output register frees up whenever its result leaves this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // sample resized to the duty width (truncate or zero-extend)
    logic [DUTY_BITS+SAMPLE_W-1:0] sample_ext;
    logic [DUTY_BITS-1:0]          sample_d;
    assign sample_ext = {{DUTY_BITS{1'b0}}, s_brightness_sample};
    assign sample_d   = sample_ext[DUTY_BITS-1:0];

    // wrap-safe elapsed tests: (now - last) mod 2^32 against the span
    time_ms_t slow_diff, strobe_diff, breath_diff;
    logic     slow_due,  strobe_due,  breath_due;
    assign slow_diff   = s_now_ms - slow_last_reg;
    assign strobe_diff = s_now_ms - strobe_last_reg;
    assign breath_diff = s_now_ms - breath_last_reg;
    assign slow_due    = slow_diff   >= {{(TIME_W-PERIOD_W){1'b0}}, slow_half_reg};
    assign strobe_due  = strobe_diff >= {{(TIME_W-PERIOD_W){1'b0}}, strobe_half_reg};
    assign breath_due  = breath_diff >= {{(TIME_W-PERIOD_W){1'b0}}, breath_intvl_reg};

    // breathing ramp step
    logic [DUTY_BITS-1:0] ramp_level;
    logic                 ramp_falling;

    lmps_breath #(
        .DUTY_BITS (DUTY_BITS)
    ) u_breath (
        .level        (breath_level_reg),
        .falling      (breath_falling_reg),
        .step         (breath_step_reg),
        .level_next   (ramp_level),
        .falling_next (ramp_falling)
    );

    // per-item update; modes not selected keep their timers and flags
    always_comb begin
        duty_next           = duty_reg;
        slow_last_next      = slow_last_reg;
        slow_on_next        = slow_on_reg;
        strobe_last_next    = strobe_last_reg;
        strobe_on_next      = strobe_on_reg;
        breath_level_next   = breath_level_reg;
        breath_last_next    = breath_last_reg;
        breath_falling_next = breath_falling_reg;
        case (mode_reg)
            MODE_DARK: begin
                duty_next = '0;
            end
            MODE_ON: begin
                duty_next = sample_d;
            end
            MODE_BLINK: begin
                if (slow_due) begin
                    slow_last_next = s_now_ms;
                    slow_on_next   = !slow_on_reg;
                    duty_next      = slow_on_reg ? '0 : sample_d;
                end
            end
            MODE_FLASH: begin
                if (strobe_due) begin
                    strobe_last_next = s_now_ms;
                    strobe_on_next   = !strobe_on_reg;
                    duty_next        = strobe_on_reg ? '0 : sample_d;
                end
            end
            MODE_BREATH: begin
                if (breath_due) begin
                    breath_last_next    = s_now_ms;
                    breath_level_next   = ramp_level;
                    breath_falling_next = ramp_falling;
                    duty_next           = ramp_level;
                end
            end
            default: ;  // unused mode codes hold everything
        endcase
    end

    // duty resized to the 10-bit result field
    logic [DUTY_BITS+DUTY_W-1:0] duty_out_ext;
    assign duty_out_ext = {{DUTY_W{1'b0}}, duty_next};

    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg           <= '0;
            slow_last_reg      <= '0;
            slow_on_reg        <= 1'b0;
            strobe_last_reg    <= '0;
            strobe_on_reg      <= 1'b0;
            breath_level_reg   <= '0;
            breath_last_reg    <= '0;
            breath_falling_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                duty_reg           <= duty_next;
                slow_last_reg      <= slow_last_next;
                slow_on_reg        <= slow_on_next;
                strobe_last_reg    <= strobe_last_next;
                strobe_on_reg      <= strobe_on_next;
                breath_level_reg   <= breath_level_next;
                breath_last_reg    <= breath_last_next;
                breath_falling_reg <= breath_falling_next;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_duty_reg <= duty_out_ext[DUTY_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_duty  = m_duty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ACLK(a_off_gives_zero,
        accept && (mode_reg == MODE_DARK) |=> m_valid && (m_duty == '0),
        "off mode item did not give a zero duty")
    `ASSERT_ACLK(a_duty_held_idle,
        !accept |=> $stable(duty_reg),
        "held duty changed without an accepted item")
    `ASSERT_ACLK(a_turn_down_at_top,
        $rose(breath_falling_reg) |-> (breath_level_reg == FULL),
        "breathing turned down below full scale")
    `ASSERT_ACLK(a_turn_up_at_bottom,
        $fell(breath_falling_reg) |-> (breath_level_reg == '0),
        "breathing turned up above zero")

endmodule

FILE: bench/led_mode_pwm_sequencer_checker.sv
// ----------------------------------------------------------------------------
// led_mode_pwm_sequencer_checker
// Watches the item and result channels and the register port of the LED PWM
// sequencer. It predicts the duty value of each accepted item and compares it
// with the oldest result still expected.
// ----------------------------------------------------------------------------
module led_mode_pwm_sequencer_checker
    import lmps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  time_ms_t              s_now_ms,
    input  logic [SAMPLE_W-1:0]   s_brightness_sample,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [DUTY_W-1:0]     m_duty,
    input  logic                  cfg_wr_en,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    duty_pending,
    output int                    duty_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DUTY_W-1:0] FULL_SCALE = '1;

    // register copies
    mode_t   mode_sel;
    period_t slow_half_ms;
    period_t strobe_half_ms;
    period_t breath_intvl_ms;
    step_t   breath_inc;

    // mode state
    logic [DUTY_W-1:0] duty_held;
    time_ms_t          slow_last;
    logic              slow_lit;
    time_ms_t          strobe_last;
    logic              strobe_lit;
    logic [DUTY_W-1:0] breath_level;
    time_ms_t          breath_last;
    logic              breath_falling;

    logic [DUTY_W-1:0] duty_q[$];
    logic [DUTY_W-1:0] want_duty;

    // unsigned difference, so a wrap of the ms counter is harmless
    function automatic bit span_elapsed(time_ms_t now, time_ms_t last, period_t span);
        time_ms_t diff;
        diff = now - last;
        return diff >= span;
    endfunction

    function void breath_advance();
        logic [DUTY_W-1:0] top_level;
        top_level = (breath_inc >= FULL_SCALE) ? '0 : FULL_SCALE - breath_inc;
        if (!breath_falling) begin
            if (breath_level >= top_level) begin
                breath_level   = FULL_SCALE;
                breath_falling = 1'b1;
            end else begin
                breath_level = breath_level + breath_inc;
            end
        end else begin
            if (breath_level <= breath_inc) begin
                breath_level   = '0;
                breath_falling = 1'b0;
            end else begin
                breath_level = breath_level - breath_inc;
            end
        end
    endfunction

    function logic [DUTY_W-1:0] predict_duty(time_ms_t now, logic [SAMPLE_W-1:0] sample);
        case (mode_sel)
            MODE_DARK: begin
                duty_held = '0;
            end
            MODE_ON: begin
                duty_held = sample;
            end
            MODE_BLINK: begin
                if (span_elapsed(now, slow_last, slow_half_ms)) begin
                    slow_last = now;
                    slow_lit  = !slow_lit;
                    duty_held = slow_lit ? sample : '0;
                end
            end
            MODE_FLASH: begin
                if (span_elapsed(now, strobe_last, strobe_half_ms)) begin
                    strobe_last = now;
                    strobe_lit  = !strobe_lit;
                    duty_held   = strobe_lit ? sample : '0;
                end
            end
            MODE_BREATH: begin
                if (span_elapsed(now, breath_last, breath_intvl_ms)) begin
                    breath_last = now;
                    breath_advance();
                    duty_held = breath_level;
                end
            end
            default: begin
                // unused codes hold the duty
            end
        endcase
        return duty_held;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_sel        = RST_LED_MODE;
            slow_half_ms    = RST_SLOW_HALF;
            strobe_half_ms  = RST_STROBE_HALF;
            breath_intvl_ms = RST_BREATH_INTVL;
            breath_inc      = RST_BREATH_STEP;
            duty_held       = '0;
            slow_last       = '0;
            slow_lit        = 1'b0;
            strobe_last     = '0;
            strobe_lit      = 1'b0;
            breath_level    = '0;
            breath_last     = '0;
            breath_falling  = 1'b0;
            fail_count      = 0;
            duty_checked    = 0;
            duty_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (duty_q.size() == 0) begin
                    $display("%0t: duty %0d arrived with no item outstanding", $time, m_duty);
                    fail_count++;
                end else begin
                    want_duty = duty_q.pop_front();
                    duty_checked++;
                    if (m_duty !== want_duty) begin
                        $display("%0t: duty mismatch, expected %0d, actual %0d",
                                 $time, want_duty, m_duty);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                duty_q.push_back(predict_duty(s_now_ms, s_brightness_sample));
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LED_MODE:     mode_sel        = cfg_wdata[MODE_W-1:0];
                    REG_SLOW_HALF:    slow_half_ms    = cfg_wdata[PERIOD_W-1:0];
                    REG_STROBE_HALF:  strobe_half_ms  = cfg_wdata[PERIOD_W-1:0];
                    REG_BREATH_INTVL: breath_intvl_ms = cfg_wdata[PERIOD_W-1:0];
                    REG_BREATH_STEP:  breath_inc      = cfg_wdata[STEP_W-1:0];
                    default: begin
                        // no such register
                    end
                endcase
            end
        end
        duty_pending = duty_q.size();
    end

endmodule

FILE: bench/led_mode_pwm_sequencer_unit_test.sv
// ----------------------------------------------------------------------------
// led_mode_pwm_sequencer_unit_test
// Drives update items and register writes into the LED PWM sequencer, with
// random stalls on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module led_mode_pwm_sequencer_unit_test;
    import lmps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 7;
    localparam int LONG_HOLD     = 300;   // receiver hold-off for the fill test
    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES  = 4;     // output register latency plus margin
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 100;

    logic                  aclk                = 1'b0;
    logic                  aresetn             = 1'b0;
    logic                  s_valid             = 1'b0;
    logic                  s_ready;
    time_ms_t              s_now_ms            = '0;
    logic [SAMPLE_W-1:0]   s_brightness_sample = '0;
    logic                  m_valid;
    logic                  m_ready             = 1'b1;
    logic [DUTY_W-1:0]     m_duty;
    logic                  cfg_wr_en           = 1'b0;
    cfg_idx_t              cfg_index           = REG_LED_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata           = '0;

    int fail_count;
    int duty_pending;
    int duty_checked;

    // knobs shared by the sender, the receiver, the watchdog and the main sequence
    bit          idling_on = 1'b1;
    bit          hold_req  = 1'b0;
    int          items_sent;
    int          settings_used;
    int          stall_cycles;
    time_ms_t    clock_ms;        // running millisecond time for ordered items

    always #6 aclk = ~aclk;

    led_mode_pwm_sequencer_unit u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_now_ms            (s_now_ms),
        .s_brightness_sample (s_brightness_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_duty              (m_duty),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata)
    );

    led_mode_pwm_sequencer_checker u_chk (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_now_ms            (s_now_ms),
        .s_brightness_sample (s_brightness_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_duty              (m_duty),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .fail_count          (fail_count),
        .duty_pending        (duty_pending),
        .duty_checked        (duty_checked)
    );

    // Watchdog: any cycle with a handshake on either channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    // Each branch ends on an edge where at most one assignment to m_ready sits.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idling_on && aresetn && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until accepted. Entered on a clock edge;
    // returns on one. The valid stays high into the next item unless a gap
    // is taken here.
    task automatic send_item(input time_ms_t now, input logic [SAMPLE_W-1:0] sample);
        s_valid             <= 1'b1;
        s_now_ms            <= now;
        s_brightness_sample <= sample;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait for every expected duty. Every item yields a
    // result, so an empty checker queue means the block is idle.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (duty_pending != 0) @(posedge aclk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly short periods so toggles come often; zero, one and full scale
    // show up now and then.
    function automatic period_t pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return period_t'(1);
            2:       return '1;
            default: return period_t'($urandom_range(2, 120));
        endcase
    endfunction

    function automatic step_t pick_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return step_t'(1);
            2:       return '1;
            default: return step_t'($urandom_range(1, 255));
        endcase
    endfunction

    // New random setting; returns the time span that suits the chosen mode.
    task automatic random_config(output int unsigned span);
        period_t slow_ms;
        period_t strobe_ms;
        period_t intvl_ms;
        step_t   inc;
        mode_t   mode;
        logic [CFG_DATA_W-1:0] mode_word;
        logic [CFG_DATA_W-1:0] step_word;
        slow_ms   = pick_period();
        strobe_ms = pick_period();
        intvl_ms  = pick_period();
        inc       = pick_step();
        mode      = ($urandom_range(0, 9) == 0) ? mode_t'($urandom_range(5, 7))
                                                : mode_t'($urandom_range(0, 4));
        // upper bits of narrow registers are don't-care; fill them sometimes
        mode_word = CFG_DATA_W'($urandom_range(0, 65535));
        step_word = CFG_DATA_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 0) begin
            mode_word = '0;
            step_word = '0;
        end
        mode_word[MODE_W-1:0] = mode;
        step_word[STEP_W-1:0] = inc;
        write_reg(REG_SLOW_HALF, slow_ms);
        write_reg(REG_STROBE_HALF, strobe_ms);
        write_reg(REG_BREATH_INTVL, intvl_ms);
        write_reg(REG_BREATH_STEP, step_word);
        if ($urandom_range(0, 3) == 0)
            write_reg(cfg_idx_t'(REG_BREATH_STEP + 1 + $urandom_range(0, 2)),
                      CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_LED_MODE, mode_word);
        settings_used++;
        case (mode)
            MODE_BLINK:  span = 32'(slow_ms);
            MODE_FLASH:  span = 32'(strobe_ms);
            MODE_BREATH: span = 32'(intvl_ms);
            default:     span = 50;
        endcase
        if (span == 0) span = 4;
    endtask

    // Mostly time moving forward in steps around the active period; the rest
    // is arbitrary time values and jumps close to the 32-bit wrap.
    task automatic run_phase(input int n_items, input int unsigned span);
        time_ms_t now;
        int       pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                clock_ms = clock_ms + $urandom_range(0, 2 * span + 2);
                now      = clock_ms;
            end else if (pick < 92) begin
                now = $urandom;
            end else begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * span + 3);
                now      = clock_ms;
            end
            send_item(now, SAMPLE_W'($urandom_range(0, 1023)));
        end
    endtask

    // Directed cases on the reset setting and a few hand-picked ones.
    task automatic directed_items();
        // off after reset: duty stays 0 whatever comes in
        send_item(32'hFFFF_FFFF, 10'h3FF);
        send_item(32'h0000_0000, 10'h000);
        // on: duty follows the sample
        write_reg(REG_LED_MODE, CFG_DATA_W'(MODE_ON));
        send_item(32'h5555_5555, 10'h3FF);
        send_item(32'hAAAA_AAAA, 10'h000);
        send_item(32'h0000_0001, 10'h2AA);
        send_item(32'h8000_0000, 10'h155);
        // slow blink, 500 ms: one short of the period holds, the period toggles
        write_reg(REG_LED_MODE, CFG_DATA_W'(MODE_BLINK));
        send_item(32'd499, 10'd700);
        send_item(32'd500, 10'd700);
        send_item(32'd999, 10'd1);
        send_item(32'd1000, 10'd1);
        // strobe, 50 ms, across the wrap of the ms counter
        write_reg(REG_LED_MODE, CFG_DATA_W'(MODE_FLASH));
        send_item(32'hFFFF_FFF0, 10'd800);
        send_item(32'h0000_0020, 10'd5);
        send_item(32'h0000_0022, 10'd9);
        // breathing with zero interval and the largest step: full ramp up,
        // clamp at full scale, ramp down, clamp at zero
        write_reg(REG_BREATH_INTVL, '0);
        write_reg(REG_BREATH_STEP, CFG_DATA_W'(step_t'('1)));
        write_reg(REG_LED_MODE, CFG_DATA_W'(MODE_BREATH));
        for (int i = 0; i < 10; i++)
            send_item(32'h1234_5678, SAMPLE_W'($urandom_range(0, 1023)));
        // zero step: level stays put
        write_reg(REG_BREATH_STEP, '0);
        send_item(32'h1234_5679, 10'd0);
        // unused mode code holds the duty; write to a missing register ignored
        write_reg(cfg_idx_t'(REG_BREATH_STEP + 1), 16'hFFFF);
        write_reg(REG_LED_MODE, CFG_DATA_W'(MODE_BREATH + 3));
        send_item(32'h0000_0000, 10'h3FF);
    endtask

    initial begin
        int unsigned span;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_items();
        clock_ms = $urandom;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // registers change only with nothing in flight
            drain_results();
            if (ph >= RANDOM_PHASES - 3)
                idling_on = 1'b0;
            random_config(span);
            // fill test: receiver stops while the sender keeps offering
            if (ph == 4)
                hold_req = 1'b1;
            run_phase(PHASE_ITEMS, span);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run: %0d update items sent, %0d duty values compared,", items_sent,
                 duty_checked);
        $display("     %0d random register settings plus directed mode and wrap cases",
                 settings_used);
        if (fail_count == 0 && duty_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, duty_pending);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/lmps_pkg.sv
sv/lmps_breath.sv
sv/led_mode_pwm_sequencer_unit.sv
bench/led_mode_pwm_sequencer_checker.sv
bench/led_mode_pwm_sequencer_unit_test.sv
